[rtl/dsd_pkg.sv]
// Shared constants, font table and helper functions for the decimal stroke digit generator.
package dsd_pkg;

  localparam int unsigned GLYPH_BITS = 15;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_BITS   = 2;

  localparam logic [IDX_BITS-1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_GLYPH_HEIGHT = 2'd1;

  // floor(u / 10) for u < 2^20 as (u * DIV_RECIP) >> DIV_SHIFT
  localparam int unsigned DIV_BITS  = 20;
  localparam int unsigned DIV_SPAN  = 327680;
  localparam int unsigned DIV_RECIP = 838861;
  localparam int unsigned DIV_SHIFT = 23;

  // segment code {x1, y1, x2, y2}, each 0 low, 1 middle, 2 high
  localparam logic [7:0] FONT_SEG [0:9][0:4] = '{
    '{8'h08, 8'h8A, 8'hA2, 8'h20, 8'h00},
    '{8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2A, 8'hA9, 8'h91, 8'h10, 8'h08},
    '{8'h2A, 8'hA9, 8'h59, 8'h98, 8'h80},
    '{8'h21, 8'h19, 8'hA8, 8'h00, 8'h00},
    '{8'hA2, 8'h21, 8'h19, 8'h98, 8'h80},
    '{8'hA2, 8'h20, 8'h08, 8'h89, 8'h91},
    '{8'h2A, 8'hA8, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'h8A, 8'hA2, 8'h20, 8'h19},
    '{8'h2A, 8'hA8, 8'h80, 8'h01, 8'h19}
  };

  localparam logic [2:0] FONT_COUNT [0:9] = '{
    3'd4, 3'd1, 3'd5, 3'd5, 3'd3, 3'd5, 3'd5, 3'd2, 3'd5, 3'd5
  };

  function automatic logic [7:0] glyph_seg(input logic [3:0] d, input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    if (d <= 4'd9 && k <= 3'd4) begin
      r = FONT_SEG[d][k];
    end
    return r;
  endfunction

  function automatic logic [2:0] glyph_count(input logic [3:0] d);
    logic [2:0] r;
    r = 3'd1;
    if (d <= 4'd9) begin
      r = FONT_COUNT[d];
    end
    return r;
  endfunction

endpackage

[rtl/dsd_front.sv]
// Front end: accepts a number, converts its magnitude to decimal digits and counts them.
module dsd_front import dsd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10,
  parameter int unsigned NW = 4,
  parameter int unsigned RW = 32 + 4 + 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic signed [COORD_BITS-1:0] anchor_x_i,
  input  logic signed [COORD_BITS-1:0] anchor_y_i,
  output logic                         enq_o,
  input  logic                         enq_full_i,
  output logic [RW-1:0]                rec_o
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_DONE} fstate_e;

  localparam int unsigned BW = 4 * MAX_DIGITS;

  fstate_e                 state_q;
  logic [4:0]              cnt_q;
  logic [VALUE_BITS-1:0]   bin_q;
  logic [BW-1:0]           bcd_q, bcd_d;
  logic                    ovf_q, ovf_d;
  logic [BW-1:0]           adj;
  logic signed [COORD_BITS-1:0] ax_q, ay_q;
  logic [NW-1:0]           n_c;
  logic [VALUE_BITS-1:0]   mag;

  assign mag = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  always_comb begin
    for (int j = 0; j < MAX_DIGITS; j++) begin
      adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3 : bcd_q[4*j +: 4];
    end
    bcd_d = {adj[BW-2:0], bin_q[VALUE_BITS-1]};
    ovf_d = ovf_q | adj[BW-1];
  end

  always_comb begin
    n_c = NW'(1);
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (bcd_q[4*j +: 4] != 4'd0) begin
        n_c = NW'(j + 1);
      end
    end
    if (ovf_q) begin
      n_c = NW'(MAX_DIGITS);
    end
  end

  assign full_o = (state_q != F_IDLE);
  assign enq_o  = (state_q == F_DONE) && !enq_full_i;
  assign rec_o  = {ay_q, ax_q, n_c, bcd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            state_q <= F_CONV;
            cnt_q   <= '0;
          end
        end
        F_CONV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (!enq_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      bin_q <= mag;
      bcd_q <= '0;
      ovf_q <= 1'b0;
      ax_q  <= anchor_x_i;
      ay_q  <= anchor_y_i;
    end else if (state_q == F_CONV) begin
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_q <= bcd_d;
      ovf_q <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CONV && cnt_q == 5'd31) |=> (state_q == F_DONE))
    else $error("conversion did not finish after 32 steps");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_IDLE && push_i) |=> (state_q == F_CONV && cnt_q == 5'd0))
    else $error("accepted beat did not start conversion");
  a_enq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_o |=> (state_q == F_IDLE))
    else $error("front did not release after enqueue");
`endif

endmodule

[rtl/dsd_queue.sv]
// Two-entry queue carrying digit records from the front end to the back end.
module dsd_queue #(
  parameter int unsigned RW = 76
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enq_i,
  input  logic [RW-1:0] enq_data_i,
  output logic          full_o,
  input  logic          deq_i,
  output logic          empty_o,
  output logic [RW-1:0] deq_data_o
);

  logic [RW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          do_wr, do_rd;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign do_wr      = enq_i && !full_o;
  assign do_rd      = deq_i && !empty_o;
  assign deq_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_q <= ~wr_q;
      end
      if (do_rd) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= enq_data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill count");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue overfilled");
  a_cnt_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q))
    else $error("queue pointers out of step");
`endif

endmodule

[rtl/dsd_back.sv]
// Back end: walks digits and font segments, scales endpoints and holds the result beat.
module dsd_back import dsd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10,
  parameter int unsigned NW = 4,
  parameter int unsigned RW = 76
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         deq_empty_i,
  output logic                         deq_o,
  input  logic [RW-1:0]                rec_i,
  input  logic [GLYPH_BITS-1:0]        glyph_width_i,
  input  logic [GLYPH_BITS-1:0]        glyph_height_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o,
  output logic                         last_segment_o
);

  typedef enum logic [1:0] {B_IDLE, B_SETUP, B_RUN} bstate_e;

  localparam int unsigned BW = 4 * MAX_DIGITS;
  localparam int unsigned DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LW = $clog2((12 * MAX_DIGITS + 12) * 32768) + 2;
  localparam int unsigned PW = 2 * DIV_BITS;

  bstate_e                 state_q;
  logic [BW-1:0]           bcd_q;
  logic [NW-1:0]           n_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q;
  logic [DW-1:0]           dig_q;
  logic [2:0]              k_q;
  logic signed [LW-1:0]    left_q;

  logic [3:0]              cur_dig;
  logic [7:0]              seg;
  logic [2:0]              seg_cnt;
  logic                    seg_last_k;
  logic signed [LW-1:0]    w_l, w5, w10, w12, nw, ax10, left0;
  logic                    s2_ready, s1_ready, gen;

  logic                    s1_v_q;
  logic [DIV_BITS-1:0]     ux1_q, ux2_q;
  logic signed [COORD_BITS-1:0] y1_q, y2_q;
  logic                    s1_last_q;

  logic                    out_v_q;
  logic [PW-1:0]           p1, p2;

  function automatic logic [DIV_BITS-1:0] x_prep(input logic signed [LW-1:0] left,
                                                 input logic signed [LW-1:0] off5,
                                                 input logic signed [LW-1:0] off10,
                                                 input logic [1:0] sel);
    logic signed [LW-1:0] t;
    logic [DIV_BITS-1:0]  u;
    case (sel)
      2'd1:    t = left + off5;
      2'd2:    t = left + off10;
      default: t = left;
    endcase
    t = t + LW'(5);
    if (t >= signed'(LW'(DIV_SPAN))) begin
      u = DIV_BITS'(2 * DIV_SPAN - 1);
    end else if (t < -signed'(LW'(DIV_SPAN))) begin
      u = '0;
    end else begin
      u = DIV_BITS'(t + LW'(DIV_SPAN));
    end
    return u;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] y_calc(input logic signed [COORD_BITS-1:0] ay,
                                                          input logic [GLYPH_BITS-1:0] h,
                                                          input logic [1:0] sel);
    logic signed [COORD_BITS+1:0] t;
    logic signed [COORD_BITS-1:0] r;
    case (sel)
      2'd1:    t = (COORD_BITS+2)'(ay) + signed'({3'b000, h[GLYPH_BITS-1:1]}) +
                   signed'({(COORD_BITS+1)'(0), h[0]});
      2'd2:    t = (COORD_BITS+2)'(ay) + signed'({3'b000, h});
      default: t = (COORD_BITS+2)'(ay);
    endcase
    if (t > (COORD_BITS+2)'(32767)) begin
      r = 16'sh7FFF;
    end else if (t < -(COORD_BITS+2)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = t[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign cur_dig    = bcd_q[4*dig_q +: 4];
  assign seg        = glyph_seg(cur_dig, k_q);
  assign seg_cnt    = glyph_count(cur_dig);
  assign seg_last_k = (k_q == seg_cnt - 3'd1);

  assign w_l   = LW'({1'b0, glyph_width_i});
  assign w5    = (w_l <<< 2) + w_l;
  assign w10   = w5 <<< 1;
  assign w12   = (w_l <<< 3) + (w_l <<< 2);
  assign nw    = LW'(n_q) * w_l;
  assign ax10  = (LW'(ax_q) <<< 3) + (LW'(ax_q) <<< 1);
  assign left0 = ax10 - ((nw <<< 2) + (nw <<< 1));

  assign s2_ready = !out_v_q || pop_i;
  assign s1_ready = !s1_v_q || s2_ready;
  assign gen      = (state_q == B_RUN) && s1_ready;
  assign deq_o    = (state_q == B_IDLE) && !deq_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      dig_q   <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!deq_empty_i) begin
            state_q <= B_SETUP;
          end
        end
        B_SETUP: begin
          state_q <= B_RUN;
          dig_q   <= DW'(n_q - NW'(1));
          k_q     <= '0;
        end
        B_RUN: begin
          if (gen) begin
            if (seg_last_k) begin
              k_q <= '0;
              if (dig_q == '0) begin
                state_q <= B_IDLE;
              end else begin
                dig_q <= dig_q - DW'(1);
              end
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (s1_ready) begin
        s1_v_q <= gen;
      end
      if (s2_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_o) begin
      bcd_q <= rec_i[BW-1:0];
      n_q   <= rec_i[BW +: NW];
      ax_q  <= rec_i[BW+NW +: COORD_BITS];
      ay_q  <= rec_i[BW+NW+COORD_BITS +: COORD_BITS];
    end
    if (state_q == B_SETUP) begin
      left_q <= left0;
    end else if (gen && seg_last_k) begin
      left_q <= left_q + w12;
    end
    if (gen) begin
      ux1_q     <= x_prep(left_q, w5, w10, seg[7:6]);
      ux2_q     <= x_prep(left_q, w5, w10, seg[3:2]);
      y1_q      <= y_calc(ay_q, glyph_height_i, seg[5:4]);
      y2_q      <= y_calc(ay_q, glyph_height_i, seg[1:0]);
      s1_last_q <= seg_last_k && (dig_q == '0);
    end
    if (s2_ready && s1_v_q) begin
      start_x_o      <= {~p1[DIV_SHIFT+COORD_BITS-1], p1[DIV_SHIFT +: COORD_BITS-1]};
      end_x_o        <= {~p2[DIV_SHIFT+COORD_BITS-1], p2[DIV_SHIFT +: COORD_BITS-1]};
      start_y_o      <= y1_q;
      end_y_o        <= y2_q;
      last_segment_o <= s1_last_q;
    end
  end

  assign p1      = PW'(ux1_q) * PW'(DIV_RECIP);
  assign p2      = PW'(ux2_q) * PW'(DIV_RECIP);
  assign empty_o = !out_v_q;

`ifndef SYNTHESIS
  a_setup_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SETUP) |=> (state_q == B_RUN))
    else $error("setup cycle not followed by run");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_ready) |=> (s1_v_q && $stable(ux1_q) && $stable(s1_last_q)))
    else $error("stage one lost a stalled beat");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RUN) |-> (k_q < seg_cnt))
    else $error("segment index beyond glyph");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RUN) |-> (DW'(dig_q) < n_q))
    else $error("digit index beyond digit count");
`endif

endmodule

[rtl/decimal_stroke_digit_generator.sv]
// Top level of the decimal stroke digit generator: registers, front end, queue, back end.
//
// Usage: write glyph_width (index 0) and glyph_height (index 1) through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; both hold their defaults after reset.
// Push a number with push/full: a beat is taken when push is high and full low.
// The front end runs a 32-step binary-to-decimal conversion (one step per cycle)
// and keeps full high until its record enters the two-entry queue to the back end,
// waiting while that queue is full. The back end passes a setup state per number,
// then emits one segment per cycle while not stalled (1 to 5*MAX_DIGITS per number)
// through a two-stage pipeline whose second stage is the result register. A result
// waits on the output ports while empty is low and leaves when pop is high; a stalled
// receiver holds the pipeline, then the queue, then the front end. The front end can
// take a new number once its record is queued, even while the back end still emits
// the segments of earlier numbers. Reset empties every stage.
module decimal_stroke_digit_generator import dsd_pkg::*; #(
  parameter int unsigned MAX_DIGITS      = 10,
  parameter int unsigned COORD_FRAC_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [IDX_BITS-1:0]          cfg_idx_i,
  input  logic [GLYPH_BITS-1:0]        cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic signed [COORD_BITS-1:0] anchor_x_i,
  input  logic signed [COORD_BITS-1:0] anchor_y_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o,
  output logic                         last_segment_o
);

  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned RW = 2 * COORD_BITS + NW + 4 * MAX_DIGITS;
  localparam int unsigned WIDTH_RST  = ((2 ** COORD_FRAC_BITS) * 10 + 50) / 100;
  localparam int unsigned HEIGHT_RST = ((2 ** COORD_FRAC_BITS) * 15 + 50) / 100;

  logic [GLYPH_BITS-1:0] glyph_width_q, glyph_height_q;
  logic                  enq, enq_full, deq, deq_empty;
  logic [RW-1:0]         rec_in, rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q  <= GLYPH_BITS'(WIDTH_RST);
      glyph_height_q <= GLYPH_BITS'(HEIGHT_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data_i;
        REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsd_front #(.MAX_DIGITS(MAX_DIGITS), .NW(NW), .RW(RW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .value_i    (value_i),
    .anchor_x_i (anchor_x_i),
    .anchor_y_i (anchor_y_i),
    .enq_o      (enq),
    .enq_full_i (enq_full),
    .rec_o      (rec_in)
  );

  dsd_queue #(.RW(RW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_data_i (rec_in),
    .full_o     (enq_full),
    .deq_i      (deq),
    .empty_o    (deq_empty),
    .deq_data_o (rec_out)
  );

  dsd_back #(.MAX_DIGITS(MAX_DIGITS), .NW(NW), .RW(RW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deq_empty_i    (deq_empty),
    .deq_o          (deq),
    .rec_i          (rec_out),
    .glyph_width_i  (glyph_width_q),
    .glyph_height_i (glyph_height_q),
    .empty_o        (empty),
    .pop_i          (pop),
    .start_x_o      (start_x_o),
    .start_y_o      (start_y_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o),
    .last_segment_o (last_segment_o)
  );

endmodule
